// ===== src/frls_pkg.sv =====
// Package for the flash record log store: shared constants, codes and types.
// Used by frls_seq and flash_record_log_store_unit; depends on nothing.
package frls_pkg;

  localparam int unsigned STORE_WORDS_DEF      = 4096;
  localparam int unsigned MAX_RECORD_BYTES_DEF = 65535;
  localparam logic [31:0] ERASED_WORD          = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    FN_BEGIN = 2'd0,
    FN_DATA  = 2'd1,
    FN_FIND  = 2'd2,
    FN_NOP   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_SIZE  = 3'd1,
    ST_NO_SPACE  = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_NO_SAVE   = 3'd4,
    ST_BUSY      = 3'd5
  } status_e;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE,
    S_W_RK, S_W_RL, S_W_LEN, S_W_END,
    S_C_RK, S_C_RL, S_C_LEN, S_C_END,
    S_I_RK, S_I_RL, S_I_LEN,
    S_P_RD, S_P_WR,
    S_X_RD, S_X_WR,
    S_H_K, S_H_L,
    S_DONE
  } state_e;

  typedef struct packed {
    status_e     status;
    logic [13:0] byte_address;
    logic [14:0] bytes_free;
    logic        save_done;
  } result_t;

endpackage

// ===== src/frls_ram.sv =====
// Generic single-port synchronous RAM with a registered read port.
// No dependencies.
module frls_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/frls_seq.sv =====
// Sequencer of the record log: header walks, compaction, header and data writes.
// Depends on frls_pkg; drives the log RAM and the scratch RAM.
module frls_seq #(
  parameter int unsigned STORE_WORDS      = frls_pkg::STORE_WORDS_DEF,
  parameter int unsigned MAX_RECORD_BYTES = frls_pkg::MAX_RECORD_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     func_i,
  input  logic [31:0]                    record_key_i,
  input  logic [15:0]                    byte_count_i,
  input  logic [31:0]                    data_word_i,
  output logic                           res_valid_o,
  input  logic                           res_take_i,
  output frls_pkg::result_t              res_o,
  output logic                           log_en_o,
  output logic                           log_we_o,
  output logic [$clog2(STORE_WORDS)-1:0] log_addr_o,
  output logic [31:0]                    log_wdata_o,
  input  logic [31:0]                    log_rdata_i,
  output logic                           scr_en_o,
  output logic                           scr_we_o,
  output logic [$clog2(STORE_WORDS)-1:0] scr_addr_o,
  output logic [31:0]                    scr_wdata_o,
  input  logic [31:0]                    scr_rdata_i
);
  import frls_pkg::*;

  localparam int unsigned AW = $clog2(STORE_WORDS);
  localparam int unsigned LW = ((AW > 14) ? AW : 14) + 2;
  localparam logic [LW-1:0] SW_L = LW'(STORE_WORDS);
  localparam logic [LW-1:0] SW_LAST = LW'(STORE_WORDS - 1);

  state_e      state_q, state_d;
  func_e       func_q, func_d;
  logic [LW-1:0] a_q, a_d, b_q, b_d, off_q, off_d, i_q, i_d, e_q, e_d;
  logic [LW-1:0] wp_q, wp_d, at_q, at_d;
  logic [13:0] wl_q, wl_d;
  logic        open_q, open_d, hit_q, hit_d, known_q, known_d, oob_q, oob_d;
  logic [31:0] key_q, key_d, ck_q, ck_d;
  logic [15:0] bytes_q, bytes_d, clen_q, clen_d;
  result_t     res_q, res_d;

  logic [31:0]   rdw;
  logic          len_big;
  logic [LW-1:0] nw_w, need_w, rec_n, n_c, a1, b1, ai, oi, e1, sum_dw;
  logic [LW+1:0] at_by, e_by, fa_by, fh_by, fd_by;

  assign rdw     = oob_q ? ERASED_WORD : log_rdata_i;
  assign len_big = rdw > 32'(MAX_RECORD_BYTES);
  assign nw_w    = LW'(bytes_q[15:2]);
  assign need_w  = nw_w + LW'(2);
  assign rec_n   = LW'(2) + LW'(rdw[15:2]);
  assign n_c     = LW'(2) + LW'(clen_q[15:2]);
  assign a1      = a_q + LW'(1);
  assign b1      = b_q + LW'(1);
  assign ai      = a_q + i_q;
  assign oi      = off_q + i_q;
  assign e1      = e_q + LW'(1);
  assign sum_dw  = wp_q + LW'(wl_q);
  assign at_by   = {at_q, 2'b00};
  assign e_by    = {e_q, 2'b00};
  assign fa_by   = {SW_L - a_q, 2'b00};
  assign fh_by   = {SW_L - (e_q + need_w), 2'b00};
  assign fd_by   = (sum_dw <= SW_L) ? {SW_L - sum_dw, 2'b00} : '0;

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      func_q  <= FN_NOP;
      a_q     <= '0;
      b_q     <= '0;
      off_q   <= '0;
      i_q     <= '0;
      e_q     <= '0;
      wp_q    <= '0;
      at_q    <= '0;
      wl_q    <= '0;
      open_q  <= 1'b0;
      hit_q   <= 1'b0;
      known_q <= 1'b0;
      oob_q   <= 1'b0;
      key_q   <= '0;
      ck_q    <= '0;
      bytes_q <= '0;
      clen_q  <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      func_q  <= func_d;
      a_q     <= a_d;
      b_q     <= b_d;
      off_q   <= off_d;
      i_q     <= i_d;
      e_q     <= e_d;
      wp_q    <= wp_d;
      at_q    <= at_d;
      wl_q    <= wl_d;
      open_q  <= open_d;
      hit_q   <= hit_d;
      known_q <= known_d;
      oob_q   <= oob_d;
      key_q   <= key_d;
      ck_q    <= ck_d;
      bytes_q <= bytes_d;
      clen_q  <= clen_d;
      res_q   <= res_d;
    end
  end

  always_comb begin
    state_d = state_q;
    func_d  = func_q;
    a_d     = a_q;
    b_d     = b_q;
    off_d   = off_q;
    i_d     = i_q;
    e_d     = e_q;
    wp_d    = wp_q;
    at_d    = at_q;
    wl_d    = wl_q;
    open_d  = open_q;
    hit_d   = hit_q;
    known_d = known_q;
    oob_d   = oob_q;
    key_d   = key_q;
    ck_d    = ck_q;
    bytes_d = bytes_q;
    clen_d  = clen_q;
    res_d   = res_q;
    log_en_o    = 1'b0;
    log_we_o    = 1'b0;
    log_addr_o  = '0;
    log_wdata_o = '0;
    scr_en_o    = 1'b0;
    scr_we_o    = 1'b0;
    scr_addr_o  = '0;
    scr_wdata_o = '0;

    unique case (state_q)
      S_CLEAR: begin
        log_en_o    = 1'b1;
        log_we_o    = 1'b1;
        log_addr_o  = a_q[AW-1:0];
        log_wdata_o = ERASED_WORD;
        if (a_q == SW_LAST) begin
          a_d     = '0;
          state_d = S_IDLE;
        end else begin
          a_d = a1;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          func_d  = func_e'(func_i);
          key_d   = record_key_i;
          bytes_d = byte_count_i;
          res_d   = '0;
          state_d = S_DONE;
          unique case (func_e'(func_i))
            FN_BEGIN: begin
              if (open_q) begin
                res_d.status = ST_BUSY;
              end else if (record_key_i == ERASED_WORD || byte_count_i[1:0] != 2'b00 ||
                           32'(byte_count_i) > 32'(MAX_RECORD_BYTES)) begin
                res_d.status = ST_BAD_SIZE;
              end else begin
                a_d     = '0;
                hit_d   = 1'b0;
                state_d = S_W_RK;
              end
            end
            FN_FIND: begin
              if (open_q) begin
                res_d.status = ST_BUSY;
              end else begin
                a_d     = '0;
                at_d    = '0;
                hit_d   = 1'b0;
                state_d = S_W_RK;
              end
            end
            FN_DATA: begin
              if (!open_q) begin
                res_d.status = ST_NO_SAVE;
              end else begin
                log_en_o    = (wp_q < SW_L);
                log_we_o    = 1'b1;
                log_addr_o  = wp_q[AW-1:0];
                log_wdata_o = data_word_i;
                wp_d        = wp_q + LW'(1);
                wl_d        = wl_q - 14'd1;
                if (wl_q == 14'd1) begin
                  open_d          = 1'b0;
                  res_d.save_done = 1'b1;
                end
                res_d.bytes_free = fd_by[14:0];
              end
            end
            FN_NOP: begin
              res_d.status = ST_OK;
            end
            default: begin
              res_d.status = ST_OK;
            end
          endcase
        end
      end
      S_W_RK: begin
        if (a_q >= SW_L) begin
          known_d = 1'b0;
          state_d = S_W_END;
        end else begin
          log_en_o   = 1'b1;
          log_addr_o = a_q[AW-1:0];
          oob_d      = 1'b0;
          state_d    = S_W_RL;
        end
      end
      S_W_RL: begin
        if (rdw == ERASED_WORD) begin
          known_d = 1'b1;
          state_d = S_W_END;
        end else begin
          if (func_q == FN_FIND && rdw == key_q) begin
            hit_d = 1'b1;
            at_d  = a_q;
          end
          oob_d      = (a1 >= SW_L);
          log_en_o   = (a1 < SW_L);
          log_addr_o = a1[AW-1:0];
          state_d    = S_W_LEN;
        end
      end
      S_W_LEN: begin
        if (len_big) begin
          known_d = 1'b0;
          state_d = S_W_END;
        end else begin
          a_d     = a_q + rec_n;
          state_d = S_W_RK;
        end
      end
      S_W_END: begin
        if (func_q == FN_FIND) begin
          res_d.status       = hit_q ? ST_OK : ST_NOT_FOUND;
          res_d.byte_address = hit_q ? at_by[13:0] : 14'd0;
          res_d.bytes_free   = known_q ? fa_by[14:0] : 15'd0;
          state_d            = S_DONE;
        end else if (known_q && (a_q + need_w <= SW_L)) begin
          e_d     = a_q;
          state_d = S_H_K;
        end else begin
          a_d     = '0;
          off_d   = '0;
          state_d = S_C_RK;
        end
      end
      S_C_RK: begin
        if (a_q >= SW_L) begin
          state_d = S_C_END;
        end else begin
          log_en_o   = 1'b1;
          log_addr_o = a_q[AW-1:0];
          oob_d      = 1'b0;
          state_d    = S_C_RL;
        end
      end
      S_C_RL: begin
        if (rdw == ERASED_WORD) begin
          state_d = S_C_END;
        end else begin
          ck_d       = rdw;
          oob_d      = (a1 >= SW_L);
          log_en_o   = (a1 < SW_L);
          log_addr_o = a1[AW-1:0];
          state_d    = S_C_LEN;
        end
      end
      S_C_LEN: begin
        if (len_big) begin
          state_d = S_C_END;
        end else begin
          clen_d = rdw[15:0];
          if (rdw != 32'd0 && ck_q != key_q) begin
            b_d     = a_q + rec_n;
            state_d = S_I_RK;
          end else begin
            a_d     = a_q + rec_n;
            state_d = S_C_RK;
          end
        end
      end
      S_I_RK: begin
        if (b_q >= SW_L) begin
          i_d     = '0;
          state_d = S_P_RD;
        end else begin
          log_en_o   = 1'b1;
          log_addr_o = b_q[AW-1:0];
          oob_d      = 1'b0;
          state_d    = S_I_RL;
        end
      end
      S_I_RL: begin
        if (rdw == ERASED_WORD) begin
          i_d     = '0;
          state_d = S_P_RD;
        end else if (rdw == ck_q) begin
          a_d     = a_q + n_c;
          state_d = S_C_RK;
        end else begin
          oob_d      = (b1 >= SW_L);
          log_en_o   = (b1 < SW_L);
          log_addr_o = b1[AW-1:0];
          state_d    = S_I_LEN;
        end
      end
      S_I_LEN: begin
        if (len_big) begin
          i_d     = '0;
          state_d = S_P_RD;
        end else begin
          b_d     = b_q + rec_n;
          state_d = S_I_RK;
        end
      end
      S_P_RD: begin
        oob_d      = (ai >= SW_L);
        log_en_o   = (ai < SW_L);
        log_addr_o = ai[AW-1:0];
        state_d    = S_P_WR;
      end
      S_P_WR: begin
        scr_en_o    = (oi < SW_L);
        scr_we_o    = 1'b1;
        scr_addr_o  = oi[AW-1:0];
        scr_wdata_o = rdw;
        if (i_q + LW'(1) == n_c) begin
          off_d   = off_q + n_c;
          a_d     = a_q + n_c;
          state_d = S_C_RK;
        end else begin
          i_d     = i_q + LW'(1);
          state_d = S_P_RD;
        end
      end
      S_C_END: begin
        if (off_q + need_w <= SW_L) begin
          a_d     = '0;
          state_d = S_X_RD;
        end else begin
          res_d.status = ST_NO_SPACE;
          state_d      = S_DONE;
        end
      end
      S_X_RD: begin
        scr_en_o   = 1'b1;
        scr_addr_o = a_q[AW-1:0];
        state_d    = S_X_WR;
      end
      S_X_WR: begin
        log_en_o    = 1'b1;
        log_we_o    = 1'b1;
        log_addr_o  = a_q[AW-1:0];
        log_wdata_o = (a_q < off_q) ? scr_rdata_i : ERASED_WORD;
        if (a_q == SW_LAST) begin
          e_d     = off_q;
          state_d = S_H_K;
        end else begin
          a_d     = a1;
          state_d = S_X_RD;
        end
      end
      S_H_K: begin
        log_en_o    = 1'b1;
        log_we_o    = 1'b1;
        log_addr_o  = e_q[AW-1:0];
        log_wdata_o = key_q;
        state_d     = S_H_L;
      end
      S_H_L: begin
        log_en_o           = 1'b1;
        log_we_o           = 1'b1;
        log_addr_o         = e1[AW-1:0];
        log_wdata_o        = {16'd0, bytes_q};
        wp_d               = e_q + LW'(2);
        wl_d               = bytes_q[15:2];
        open_d             = (bytes_q[15:2] != 14'd0);
        res_d.status       = ST_OK;
        res_d.byte_address = e_by[13:0];
        res_d.bytes_free   = fh_by[14:0];
        res_d.save_done    = (bytes_q[15:2] == 14'd0);
        state_d            = S_DONE;
      end
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  a_open_owes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> (wl_q != 14'd0))
    else $error("open save owes no data words");

  a_open_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> (sum_dw <= SW_L))
    else $error("open save runs past the store");

  a_pack_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_P_WR) |-> (off_q <= a_q))
    else $error("compaction write overtook its read");

  a_open_from_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(open_q) |-> ($past(state_q) == S_H_L))
    else $error("save opened without a header write");

endmodule

// ===== src/flash_record_log_store_unit.sv =====
// Top level of the flash record log store: log RAM, scratch RAM, sequencer and
// the result register. Depends on frls_pkg, frls_ram and frls_seq.
//
// Usage: one item on the input channel (func, record key, byte count, data word)
// gives exactly one item on the output channel (status, byte address, bytes
// free, save done). Both channels use valid/ready.
// A data word, an unused func code and a request refused at once pass from
// idle straight to the done state and on into the output register; the next
// item can be accepted once the sequencer is back in idle. A find walks the
// record headers in the log, reading the key word and length word of each. A
// begin-save walks the headers the same way, then writes the header's key and
// length words. When the log end is unknown or the record does not fit,
// compaction runs first: a walk over the record headers, for every candidate
// record a walk over the later headers, a copy of each kept word into the
// scratch RAM, then the write-back of the packed log and the erase of the
// rest. All cost is set by the single port of the log RAM. After reset the
// block erases the log RAM, one word per cycle, and accepts no item meanwhile.
// The result register lets the next item be accepted while a result waits; if
// the receiver stalls, a second result holds the sequencer until it drains.
module flash_record_log_store_unit #(
  parameter int unsigned STORE_WORDS      = frls_pkg::STORE_WORDS_DEF,
  parameter int unsigned MAX_RECORD_BYTES = frls_pkg::MAX_RECORD_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] record_key_i,
  input  logic [15:0] byte_count_i,
  input  logic [31:0] data_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [13:0] byte_address_o,
  output logic [14:0] bytes_free_o,
  output logic        save_done_o
);
  import frls_pkg::*;

  localparam int unsigned AW = $clog2(STORE_WORDS);

  logic          log_en, log_we, scr_en, scr_we;
  logic [AW-1:0] log_addr, scr_addr;
  logic [31:0]   log_wdata, log_rdata, scr_wdata, scr_rdata;
  logic          res_valid, res_take;
  result_t       res, out_q, out_d;
  logic          out_valid_q, out_valid_d;

  frls_ram #(.WIDTH(32), .DEPTH(STORE_WORDS)) u_log_ram (
    .clk_i   (clk_i),
    .en_i    (log_en),
    .we_i    (log_we),
    .addr_i  (log_addr),
    .wdata_i (log_wdata),
    .rdata_o (log_rdata)
  );

  frls_ram #(.WIDTH(32), .DEPTH(STORE_WORDS)) u_scr_ram (
    .clk_i   (clk_i),
    .en_i    (scr_en),
    .we_i    (scr_we),
    .addr_i  (scr_addr),
    .wdata_i (scr_wdata),
    .rdata_o (scr_rdata)
  );

  frls_seq #(
    .STORE_WORDS      (STORE_WORDS),
    .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .record_key_i (record_key_i),
    .byte_count_i (byte_count_i),
    .data_word_i  (data_word_i),
    .res_valid_o  (res_valid),
    .res_take_i   (res_take),
    .res_o        (res),
    .log_en_o     (log_en),
    .log_we_o     (log_we),
    .log_addr_o   (log_addr),
    .log_wdata_o  (log_wdata),
    .log_rdata_i  (log_rdata),
    .scr_en_o     (scr_en),
    .scr_we_o     (scr_we),
    .scr_addr_o   (scr_addr),
    .scr_wdata_o  (scr_wdata),
    .scr_rdata_i  (scr_rdata)
  );

  assign res_take = res_valid && (!out_valid_q || out_ready_i);

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (res_take) begin
      out_d       = res;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign byte_address_o = out_q.byte_address;
  assign bytes_free_o   = out_q.bytes_free;
  assign save_done_o    = out_q.save_done;

endmodule

// ===== tb/flash_record_log_store_unit_test.sv =====
`timescale 1ns / 100ps
// Testbench for flash_record_log_store_unit: directed table with compaction walks that run out
// of space, and random save/find sequences, checked against fixed rows or a bench log model.
// Depends on frls_pkg and the RTL of flash_record_log_store_unit.
module flash_record_log_store_unit_test;
  import frls_pkg::*;

  localparam int unsigned LOG_BYTES = STORE_WORDS_DEF * 4;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct {
    func_e       fn;
    logic [31:0] key;
    logic [15:0] bytes;
    logic [31:0] data;
    bit          fixed;
    result_t     res;
  } step_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready_o;
  logic [1:0]  func;
  logic [31:0] record_key;
  logic [15:0] byte_count;
  logic [31:0] data_word;
  logic        out_valid_o;
  logic        out_ready;
  logic [2:0]  status_o;
  logic [13:0] byte_address_o;
  logic [14:0] bytes_free_o;
  logic        save_done_o;

  logic [31:0] log_mem [STORE_WORDS_DEF];
  logic [31:0] pack_mem [STORE_WORDS_DEF];
  int unsigned next_word;
  int unsigned owed_words;
  bit          saving;

  result_t     pending_results [$];
  int          fail_count;
  bit          idle_on;
  bit          hold_req;
  longint      cycle_count;
  int          items_sent;

  flash_record_log_store_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .func_i        (func),
    .record_key_i  (record_key),
    .byte_count_i  (byte_count),
    .data_word_i   (data_word),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .status_o      (status_o),
    .byte_address_o(byte_address_o),
    .bytes_free_o  (bytes_free_o),
    .save_done_o   (save_done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] peek(int unsigned byte_addr);
    return (byte_addr / 4 < STORE_WORDS_DEF) ? log_mem[byte_addr / 4] : ERASED_WORD;
  endfunction

  function automatic bit log_tail(output int unsigned tail);
    int unsigned a;
    a = 0;
    tail = 0;
    while (a < LOG_BYTES) begin
      if (peek(a) == ERASED_WORD) begin
        tail = a;
        return 1'b1;
      end
      if (peek(a + 4) > MAX_RECORD_BYTES_DEF) return 1'b0;
      a += 8 + peek(a + 4);
    end
    return 1'b0;
  endfunction

  function automatic bit latest_copy(logic [31:0] key, output int unsigned at);
    int unsigned a;
    bit hit;
    a = 0;
    hit = 1'b0;
    at = 0;
    while (a < LOG_BYTES) begin
      if (peek(a) == ERASED_WORD) break;
      if (peek(a) == key) begin
        at = a;
        hit = 1'b1;
      end
      if (peek(a + 4) > MAX_RECORD_BYTES_DEF) break;
      a += 8 + peek(a + 4);
    end
    return hit;
  endfunction

  function automatic int unsigned kept_bytes(logic [31:0] except, bit copy);
    int unsigned a, off, len, at, n;
    logic [31:0] k;
    a = 0;
    off = 0;
    while (a < LOG_BYTES) begin
      k = peek(a);
      if (k == ERASED_WORD) break;
      len = peek(a + 4);
      if (len > MAX_RECORD_BYTES_DEF) break;
      if (len > 0 && k != except && latest_copy(k, at) && at == a) begin
        n = (8 + len + 3) / 4;
        if (copy) begin
          for (int unsigned i = 0; i < n; i++) begin
            if (off / 4 + i < STORE_WORDS_DEF) pack_mem[off / 4 + i] = peek(a + 4 * i);
          end
        end
        off += 4 * n;
      end
      a += 8 + len;
    end
    return off;
  endfunction

  function automatic result_t apply_request(func_e fn, logic [31:0] key, logic [15:0] bytes,
                                            logic [31:0] data);
    result_t r;
    int unsigned tail, need, size, at, used;
    bit ok;
    r = '{status: ST_OK, byte_address: '0, bytes_free: '0, save_done: 1'b0};
    case (fn)
      FN_BEGIN: begin
        if (saving) begin
          r.status = ST_BUSY;
        end else if (key == ERASED_WORD || bytes[1:0] != 2'b00 ||
                     32'(bytes) > MAX_RECORD_BYTES_DEF) begin
          r.status = ST_BAD_SIZE;
        end else begin
          need = 8 + bytes;
          ok = log_tail(tail) && tail + need <= LOG_BYTES;
          if (!ok) begin
            size = kept_bytes(key, 1'b0);
            if (size + need <= LOG_BYTES) begin
              size = kept_bytes(key, 1'b1);
              for (int i = 0; i < STORE_WORDS_DEF; i++) begin
                log_mem[i] = (i < size / 4) ? pack_mem[i] : ERASED_WORD;
              end
              tail = size;
              ok = 1'b1;
            end
          end
          if (!ok) begin
            r.status = ST_NO_SPACE;
          end else begin
            log_mem[tail / 4] = key;
            log_mem[tail / 4 + 1] = 32'(bytes);
            next_word = tail / 4 + 2;
            owed_words = bytes / 4;
            saving = owed_words != 0;
            r.save_done = !saving;
            r.byte_address = 14'(tail);
            r.bytes_free = 15'(LOG_BYTES - (tail + need));
          end
        end
      end
      FN_DATA: begin
        if (!saving) begin
          r.status = ST_NO_SAVE;
        end else begin
          if (next_word < STORE_WORDS_DEF) log_mem[next_word] = data;
          next_word++;
          owed_words--;
          if (owed_words == 0) begin
            saving = 1'b0;
            r.save_done = 1'b1;
          end
          used = 4 * (next_word + owed_words);
          r.bytes_free = (used <= LOG_BYTES) ? 15'(LOG_BYTES - used) : '0;
        end
      end
      FN_FIND: begin
        if (saving) begin
          r.status = ST_BUSY;
        end else begin
          if (latest_copy(key, at)) r.byte_address = 14'(at);
          else r.status = ST_NOT_FOUND;
          if (log_tail(tail)) r.bytes_free = 15'(LOG_BYTES - tail);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic offer(func_e fn, logic [31:0] key, logic [15:0] bytes, logic [31:0] data);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    func       <= fn;
    record_key <= key;
    byte_count <= bytes;
    data_word  <= data;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_checked(func_e fn, logic [31:0] key, logic [15:0] bytes,
                              logic [31:0] data);
    pending_results.push_back(apply_request(fn, key, bytes, data));
    offer(fn, key, bytes, data);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_sequence();
    logic [31:0] key;
    int unsigned words;
    key = ($urandom_range(0, 9) == 0) ? $urandom() : 32'($urandom_range(0, 7));
    words = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 8);
    send_checked(FN_BEGIN, key, 16'(4 * words), '0);
    while (saving) begin
      case ($urandom_range(0, 19))
        0: send_checked(FN_FIND, $urandom_range(0, 7), '0, '0);
        1: send_checked(FN_BEGIN, $urandom_range(0, 7), 16'd4, '0);
        default: send_checked(FN_DATA, $urandom(), 16'($urandom()), $urandom());
      endcase
    end
  endtask

  task automatic random_noise();
    case ($urandom_range(0, 5))
      0: send_checked(FN_DATA, $urandom(), 16'($urandom()), $urandom());
      1: send_checked(FN_NOP, $urandom(), 16'($urandom()), $urandom());
      2: send_checked(FN_BEGIN, $urandom_range(0, 7), 16'($urandom_range(0, 64)), $urandom());
      3: send_checked(FN_BEGIN, ERASED_WORD, 16'(4 * $urandom_range(0, 4)), '0);
      4: send_checked(FN_FIND, $urandom(), 16'($urandom()), $urandom());
      default: send_checked(FN_FIND, $urandom_range(0, 7), '0, '0);
    endcase
  endtask

  initial begin
    out_ready <= 1'b0;
    wait (rst_ni);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with none expected: status %0d", status_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (status_o != want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          fail_count++;
        end
        if (byte_address_o != want.byte_address) begin
          $error("byte_address: expected %0d, got %0d", want.byte_address, byte_address_o);
          fail_count++;
        end
        if (bytes_free_o != want.bytes_free) begin
          $error("bytes_free: expected %0d, got %0d", want.bytes_free, bytes_free_o);
          fail_count++;
        end
        if (save_done_o != want.save_done) begin
          $error("save_done: expected %0d, got %0d", want.save_done, save_done_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("flash_record_log_store_unit_test failed");
      $finish;
    end
  end

  initial begin
    step_row_t table_rows [$];
    result_t got;
    table_rows = '{
      '{FN_FIND,  32'd5,        16'd0,     32'd0,        1'b1, '{ST_NOT_FOUND, 14'd0, 15'd16384, 1'b0}},
      '{FN_DATA,  32'd0,        16'd0,     32'h1234_5678, 1'b1, '{ST_NO_SAVE, 14'd0, 15'd0, 1'b0}},
      '{FN_NOP,   32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 14'd0, 15'd0, 1'b0}},
      '{FN_BEGIN, 32'hFFFF_FFFF, 16'd4,    32'd0,        1'b1, '{ST_BAD_SIZE, 14'd0, 15'd0, 1'b0}},
      '{FN_BEGIN, 32'd1,        16'd3,     32'd0,        1'b1, '{ST_BAD_SIZE, 14'd0, 15'd0, 1'b0}},
      '{FN_BEGIN, 32'd0,        16'd0,     32'd0,        1'b1, '{ST_OK, 14'd0, 15'd16376, 1'b1}},
      '{FN_BEGIN, 32'd1,        16'd8,     32'd0,        1'b1, '{ST_OK, 14'd8, 15'd16360, 1'b0}},
      '{FN_FIND,  32'd1,        16'd0,     32'd0,        1'b1, '{ST_BUSY, 14'd0, 15'd0, 1'b0}},
      '{FN_BEGIN, 32'd2,        16'd4,     32'd0,        1'b1, '{ST_BUSY, 14'd0, 15'd0, 1'b0}},
      '{FN_DATA,  32'd0,        16'd0,     32'hFFFF_FFFF, 1'b0, '{ST_OK, 14'd0, 15'd0, 1'b0}},
      '{FN_DATA,  32'd0,        16'd0,     32'h0000_0000, 1'b0, '{ST_OK, 14'd0, 15'd0, 1'b0}},
      '{FN_FIND,  32'd1,        16'd0,     32'd0,        1'b0, '{ST_OK, 14'd0, 15'd0, 1'b0}},
      '{FN_FIND,  32'd0,        16'd0,     32'd0,        1'b0, '{ST_OK, 14'd0, 15'd0, 1'b0}},
      '{FN_BEGIN, 32'd2,        16'd65532, 32'd0,        1'b1, '{ST_NO_SPACE, 14'd0, 15'd0, 1'b0}},
      '{FN_BEGIN, 32'd2,        16'd65535, 32'd0,        1'b1, '{ST_BAD_SIZE, 14'd0, 15'd0, 1'b0}},
      '{FN_FIND,  32'hFFFF_FFFF, 16'd0,    32'd0,        1'b0, '{ST_OK, 14'd0, 15'd0, 1'b0}},
      '{FN_BEGIN, 32'hFFFF_FFFE, 16'd16376, 32'd0,       1'b1, '{ST_NO_SPACE, 14'd0, 15'd0, 1'b0}},
      '{FN_BEGIN, 32'd3,        16'd4,     32'd0,        1'b0, '{ST_OK, 14'd0, 15'd0, 1'b0}},
      '{FN_DATA,  32'hFFFF_FFFF, 16'hFFFF, 32'hA5A5_5A5A, 1'b0, '{ST_OK, 14'd0, 15'd0, 1'b0}}
    };
    for (int i = 0; i < STORE_WORDS_DEF; i++) log_mem[i] = ERASED_WORD;
    next_word = 0;
    owed_words = 0;
    saving = 1'b0;
    fail_count = 0;
    items_sent = 0;
    cycle_count = 0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    rst_ni <= 1'b0;
    in_valid <= 1'b0;
    func <= FN_NOP;
    record_key <= '0;
    byte_count <= '0;
    data_word <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (table_rows[i]) begin
      got = apply_request(table_rows[i].fn, table_rows[i].key, table_rows[i].bytes,
                          table_rows[i].data);
      pending_results.push_back(table_rows[i].fixed ? table_rows[i].res : got);
      offer(table_rows[i].fn, table_rows[i].key, table_rows[i].bytes, table_rows[i].data);
    end
    drain_results();

    hold_req = 1'b1;
    for (int i = 0; i < 20; i++) random_noise();
    drain_results();

    while (items_sent < 700) begin
      if ($urandom_range(0, 3) == 0) random_noise();
      else random_sequence();
    end
    drain_results();
    idle_on = 1'b0;
    for (int i = 0; i < 30; i++) random_sequence();
    drain_results();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("flash_record_log_store_unit_test passed");
    end else begin
      $display("flash_record_log_store_unit_test failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
src/frls_pkg.sv
src/frls_ram.sv
src/frls_seq.sv
src/flash_record_log_store_unit.sv
tb/flash_record_log_store_unit_test.sv
